// File: rtl/core/pcrb_pkg.sv
package pcrb_pkg;

	// Widest delay line the bank is built for sets the width of line positions.
	localparam int POS_W = 13;
	localparam int CFG_W = 23;
	localparam int MIN_DELAY = 2;
	localparam logic [22:0] ONE_Q22 = 23'd4194304;
	localparam logic [22:0] SMOOTH_RESET = 23'd2282130;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SMOOTH = 1'b1;

	typedef struct packed {
		logic start;
		logic clear;
		logic mode;
		logic in_range;
		logic [3:0] res;
		logic [POS_W-1:0] wpos;
		logic [POS_W-1:0] rd0;
		logic [POS_W-1:0] rd1;
		logic [15:0] frac;
		logic [21:0] gain;
		logic [22:0] smooth;
		logic signed [23:0] coef_cos;
		logic signed [23:0] coef_sin;
		logic [22:0] scale;
	} lane_cmd_t;

	typedef struct packed {
		logic clearing;
		logic done;
		logic signed [31:0] wet;
	} lane_stat_t;

endpackage

// File: rtl/core/pcrb_lane.sv
module pcrb_lane
	import pcrb_pkg::*;
#(
	parameter int NUM_RESONATORS = 12,
	parameter int DELAY_LENGTH = 2048
) (
	input logic clk,
	input logic arst_n,
	input lane_cmd_t cmd,
	input logic signed [31:0] sample,
	input logic ack,
	output lane_stat_t stat
);

	localparam int RW = (NUM_RESONATORS > 1) ? $clog2(NUM_RESONATORS) : 1;
	localparam int MEM_DEPTH = NUM_RESONATORS * DELAY_LENGTH;
	localparam int MAW = $clog2(MEM_DEPTH);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_B_MUL = 4'd2;
	localparam logic [3:0] ST_B_SUM = 4'd3;
	localparam logic [3:0] ST_C_RD1 = 4'd4;
	localparam logic [3:0] ST_C_RD2 = 4'd5;
	localparam logic [3:0] ST_C_D = 4'd6;
	localparam logic [3:0] ST_C_LPM = 4'd7;
	localparam logic [3:0] ST_C_LP = 4'd8;
	localparam logic [3:0] ST_C_GM = 4'd9;
	localparam logic [3:0] ST_C_Y = 4'd10;
	localparam logic [3:0] ST_SCALE = 4'd11;
	localparam logic [3:0] ST_FIN = 4'd12;
	localparam logic [3:0] ST_DONE = 4'd13;

	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int n);
		logic signed [63:0] half;
		half = 64'sd1 <<< (n - 1);
		return (x + half) >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	logic [3:0] st_q;
	logic [MAW-1:0] clr_cnt_q;
	logic signed [31:0] real_q [NUM_RESONATORS];
	logic signed [31:0] imag_q [NUM_RESONATORS];
	logic signed [31:0] lp_st_q [NUM_RESONATORS];

	lane_cmd_t cmd_q;
	logic signed [31:0] x_q;
	logic [MAW-1:0] base_q;
	logic signed [55:0] pa_q, pb_q, pc_q, pd_q;
	logic signed [58:0] prod_q;
	logic signed [31:0] b0_q;
	logic signed [33:0] d_q;
	logic signed [31:0] lp_q;
	logic signed [31:0] y_q;
	logic signed [31:0] wet_q;

	logic signed [31:0] mem [MEM_DEPTH];
	logic signed [31:0] mem_rd_q;
	logic mem_we;
	logic [MAW-1:0] mem_wa, mem_ra, base_in;
	logic signed [31:0] mem_wd;

	logic [RW-1:0] idx;
	logic signed [31:0] u_cur, v_cur, lp_cur;
	logic signed [55:0] m_cu, m_sv, m_su, m_cv;
	logic signed [56:0] s_re, s_im;
	logic signed [32:0] diff33;
	logic signed [16:0] fr17;
	logic signed [49:0] m_int;
	logic signed [34:0] dl35;
	logic signed [23:0] a24, s24;
	logic signed [22:0] g23;
	logic signed [58:0] m_lp;
	logic signed [54:0] m_g;
	logic signed [55:0] m_s;
	logic signed [63:0] t_re, t_im, t_x, t_b0, t_lp, t_prod;
	logic signed [31:0] nu, nv, lp_next, y_next, wet_next;
	logic signed [33:0] d_next;

	assign idx = RW'(cmd_q.res);
	assign u_cur = real_q[idx];
	assign v_cur = imag_q[idx];
	assign lp_cur = lp_st_q[idx];
	assign base_in = MAW'(int'(cmd.res) * DELAY_LENGTH);

	always_comb begin
		m_cu = cmd_q.coef_cos * u_cur;
		m_sv = cmd_q.coef_sin * v_cur;
		m_su = cmd_q.coef_sin * u_cur;
		m_cv = cmd_q.coef_cos * v_cur;
		s_re = pa_q - pb_q;
		s_im = pc_q + pd_q;
		diff33 = mem_rd_q - b0_q;
		fr17 = $signed({1'b0, cmd_q.frac});
		m_int = fr17 * diff33;
		dl35 = d_q - lp_cur;
		a24 = $signed({1'b0, cmd_q.smooth});
		m_lp = a24 * dl35;
		g23 = $signed({1'b0, cmd_q.gain});
		m_g = g23 * lp_q;
		s24 = $signed({1'b0, cmd_q.scale});
		m_s = s24 * y_q;

		t_re = s_re;
		t_im = s_im;
		t_x = x_q;
		t_b0 = b0_q;
		t_lp = lp_cur;
		t_prod = prod_q;
		nu = sat32(t_x + rnd_shr(t_re, 22));
		nv = sat32(rnd_shr(t_im, 22));
		d_next = 34'(t_b0 + rnd_shr(t_prod, 16));
		lp_next = sat32(t_lp + rnd_shr(t_prod, 22));
		y_next = sat32(t_x + rnd_shr(t_prod, 22));
		wet_next = sat32(rnd_shr(t_prod, 22));
	end

	// One read port and one write port; the clearing pass owns the write port.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = MAW'(base_q + MAW'(cmd_q.wpos));
		mem_wd = y_q;
		mem_ra = MAW'(base_q + MAW'(cmd_q.rd1));
		if (st_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else if (st_q == ST_SCALE && cmd_q.mode) begin
			mem_we = 1'b1;
		end
		if (st_q == ST_IDLE) begin
			mem_ra = MAW'(base_in + MAW'(cmd.rd0));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			for (int i = 0; i < NUM_RESONATORS; i++) begin
				real_q[i] <= '0;
				imag_q[i] <= '0;
				lp_st_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			st_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			for (int i = 0; i < NUM_RESONATORS; i++) begin
				real_q[i] <= '0;
				imag_q[i] <= '0;
				lp_st_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_CLEAR: begin
					if (clr_cnt_q == MAW'(MEM_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.start) begin
						if (!cmd.in_range) begin
							st_q <= ST_DONE;
						end else if (cmd.mode) begin
							st_q <= ST_C_RD1;
						end else begin
							st_q <= ST_B_MUL;
						end
					end
				end
				ST_B_MUL: st_q <= ST_B_SUM;
				ST_B_SUM: begin
					real_q[idx] <= nu;
					imag_q[idx] <= nv;
					st_q <= ST_SCALE;
				end
				ST_C_RD1: st_q <= ST_C_RD2;
				ST_C_RD2: st_q <= ST_C_D;
				ST_C_D: st_q <= ST_C_LPM;
				ST_C_LPM: st_q <= ST_C_LP;
				ST_C_LP: begin
					lp_st_q[idx] <= lp_next;
					st_q <= ST_C_GM;
				end
				ST_C_GM: st_q <= ST_C_Y;
				ST_C_Y: st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_FIN;
				ST_FIN: st_q <= ST_DONE;
				ST_DONE: begin
					if (ack) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (cmd.start) begin
					cmd_q <= cmd;
					x_q <= sample;
					base_q <= base_in;
					wet_q <= '0;
				end
			end
			ST_B_MUL: begin
				pa_q <= m_cu;
				pb_q <= m_sv;
				pc_q <= m_su;
				pd_q <= m_cv;
			end
			ST_B_SUM: y_q <= nv;
			ST_C_RD1: b0_q <= mem_rd_q;
			ST_C_RD2: prod_q <= m_int;
			ST_C_D: d_q <= d_next;
			ST_C_LPM: prod_q <= m_lp;
			ST_C_LP: lp_q <= lp_next;
			ST_C_GM: prod_q <= m_g;
			ST_C_Y: y_q <= y_next;
			ST_SCALE: prod_q <= m_s;
			ST_FIN: wet_q <= wet_next;
			default: ;
		endcase
	end

	assign stat.clearing = (st_q == ST_CLEAR);
	assign stat.done = (st_q == ST_DONE);
	assign stat.wet = wet_q;

endmodule

// File: rtl/core/pcrb_merge.sv
module pcrb_merge
	import pcrb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input lane_stat_t stat_left,
	input lane_stat_t stat_right,
	output logic ack,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] wet_left,
	output logic signed [31:0] wet_right
);

	logic valid_q;

	// Both lanes finish together; their pair moves into the output register at once.
	assign ack = stat_left.done && stat_right.done && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ack) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			wet_left <= stat_left.wet;
			wet_right <= stat_right.wet;
		end
	end

	assign out_valid = valid_q;

endmodule

// File: rtl/core/phasor_and_comb_resonator_bank.sv
// Each lane walks one item through its multipliers and delay memory, and input opens once
// the pair reaches the output register, where it may wait while the next item is taken. An
// out-of-range resonator skips the band and comb arithmetic and gives a zero result.
// Reset, and every write of the mode register, starts a clearing pass over all
// NUM_RESONATORS*DELAY_LENGTH delay words (24576 by default) during which in_ready is low.
module phasor_and_comb_resonator_bank
	import pcrb_pkg::*;
#(
	parameter int NUM_RESONATORS = 12,
	parameter int DELAY_LENGTH = 2048
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] res_index,
	input logic signed [31:0] in_left,
	input logic signed [31:0] in_right,
	input logic signed [23:0] coef_cos,
	input logic signed [23:0] coef_sin,
	input logic [22:0] out_scale,
	input logic [10:0] delay_whole,
	input logic [15:0] delay_frac,
	input logic [21:0] comb_gain,
	input logic sample_end,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] wet_left,
	output logic signed [31:0] wet_right
);

	localparam int PW = $clog2(DELAY_LENGTH);
	localparam int CW = ((PW > 11) ? PW : 11) + 2;

	logic mode_q;
	logic [22:0] smooth_q;
	logic [PW-1:0] wpos_q;
	logic busy_q;
	logic accept, mode_wr, ack;
	logic [CW-1:0] wh, r0;
	logic [15:0] fr;
	logic [PW-1:0] rd0, rd1;
	lane_cmd_t cmd;
	lane_stat_t stat_left, stat_right;

	assign cfg_ready = 1'b1;
	assign mode_wr = cfg_valid && cfg_ready && (cfg_index == REG_MODE);
	assign in_ready = !busy_q && !stat_left.clearing && !stat_right.clearing;
	assign accept = in_valid && in_ready;

	// Delay clamp and tap positions, shared by both lanes.
	always_comb begin
		wh = CW'(delay_whole);
		fr = delay_frac;
		if (wh < CW'(MIN_DELAY)) begin
			wh = CW'(MIN_DELAY);
			fr = '0;
		end else if (wh >= CW'(DELAY_LENGTH - 3)) begin
			wh = CW'(DELAY_LENGTH - 3);
			fr = '0;
		end
		r0 = CW'(wpos_q) + CW'(DELAY_LENGTH) - wh;
		if (r0 >= CW'(DELAY_LENGTH)) begin
			r0 = r0 - CW'(DELAY_LENGTH);
		end
		rd0 = PW'(r0);
		rd1 = (rd0 == '0) ? PW'(DELAY_LENGTH - 1) : rd0 - 1'b1;
	end

	always_comb begin
		cmd.start = accept;
		cmd.clear = mode_wr;
		cmd.mode = mode_q;
		cmd.in_range = (int'(res_index) < NUM_RESONATORS);
		cmd.res = res_index;
		cmd.wpos = POS_W'(wpos_q);
		cmd.rd0 = POS_W'(rd0);
		cmd.rd1 = POS_W'(rd1);
		cmd.frac = fr;
		cmd.gain = comb_gain;
		cmd.smooth = (smooth_q > ONE_Q22) ? ONE_Q22 : smooth_q;
		cmd.coef_cos = coef_cos;
		cmd.coef_sin = coef_sin;
		cmd.scale = out_scale;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			smooth_q <= SMOOTH_RESET;
			wpos_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[0];
					REG_SMOOTH: smooth_q <= cfg_data;
					default: ;
				endcase
			end
			if (mode_wr) begin
				wpos_q <= '0;
			end else if (accept && mode_q && sample_end) begin
				wpos_q <= (wpos_q == PW'(DELAY_LENGTH - 1)) ? '0 : wpos_q + 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ack) begin
				busy_q <= 1'b0;
			end
		end
	end

	pcrb_lane #(
		.NUM_RESONATORS(NUM_RESONATORS),
		.DELAY_LENGTH(DELAY_LENGTH)
	) u_lane_left (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sample(in_left),
		.ack(ack),
		.stat(stat_left)
	);

	pcrb_lane #(
		.NUM_RESONATORS(NUM_RESONATORS),
		.DELAY_LENGTH(DELAY_LENGTH)
	) u_lane_right (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sample(in_right),
		.ack(ack),
		.stat(stat_right)
	);

	pcrb_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.stat_left(stat_left),
		.stat_right(stat_right),
		.ack(ack),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wet_left(wet_left),
		.wet_right(wet_right)
	);

endmodule

// File: rtl/core/pcrb_checker.sv
module pcrb_checker
	import pcrb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_index,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [31:0] wet_left,
	input logic signed [31:0] wet_right
);

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// A mode write starts the clearing pass, which holds off input.
	a_mode_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == REG_MODE |=> !in_ready)
		else $error("input open right after a mode write");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wet_left) && $stable(wet_right))
		else $error("stalled result changed or dropped");

	a_out_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without a transfer");

endmodule

bind phasor_and_comb_resonator_bank pcrb_checker u_pcrb_checker (.*);

// File: sim/tb_phasor_and_comb_resonator_bank.sv
module tb_phasor_and_comb_resonator_bank;
	import pcrb_pkg::*;

	localparam int NRES = 12;
	localparam int DLEN = 2048;
	localparam int NCH = 2 * NRES;
	localparam int SETTLE = 20;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic [3:0] res;
		logic signed [31:0] x_l;
		logic signed [31:0] x_r;
		logic signed [23:0] c;
		logic signed [23:0] s;
		logic [22:0] scale;
		logic [10:0] whole;
		logic [15:0] frac;
		logic [21:0] gain;
		logic sample_last;
	} bank_item_t;

	typedef struct {
		logic signed [31:0] l;
		logic signed [31:0] r;
	} wet_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [3:0] res_index;
	logic signed [31:0] in_left;
	logic signed [31:0] in_right;
	logic signed [23:0] coef_cos;
	logic signed [23:0] coef_sin;
	logic [22:0] out_scale;
	logic [10:0] delay_whole;
	logic [15:0] delay_frac;
	logic [21:0] comb_gain;
	logic sample_end;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] wet_left;
	logic signed [31:0] wet_right;

	// Model state of the bank.
	logic bank_mode;
	logic [22:0] smooth_coef;
	int phasor_u[NCH];
	int phasor_v[NCH];
	int smoother[NCH];
	int dline[NCH*DLEN];
	int wpos;

	wet_pair_t wet_q[$];
	int send_idle_pct;
	int recv_idle_pct;
	int n_errors;
	int n_items;
	int n_results;
	int n_cfg;
	int stall_cycles;

	phasor_and_comb_resonator_bank #(
		.NUM_RESONATORS(NRES),
		.DELAY_LENGTH(DLEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.res_index(res_index),
		.in_left(in_left),
		.in_right(in_right),
		.coef_cos(coef_cos),
		.coef_sin(coef_sin),
		.out_scale(out_scale),
		.delay_whole(delay_whole),
		.delay_frac(delay_frac),
		.comb_gain(comb_gain),
		.sample_end(sample_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.wet_left(wet_left),
		.wet_right(wet_right)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint rnd_shr(longint x, int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic int sat32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return int'(x);
	endfunction

	function automatic void clear_bank();
		for (int i = 0; i < NCH; i++) begin
			phasor_u[i] = 0;
			phasor_v[i] = 0;
			smoother[i] = 0;
		end
		for (int i = 0; i < NCH * DLEN; i++)
			dline[i] = 0;
		wpos = 0;
	endfunction

	function automatic int band_lane(int ch, longint x, longint c, longint s, longint scale);
		longint u;
		longint v;
		u = phasor_u[ch];
		v = phasor_v[ch];
		phasor_u[ch] = sat32(x + rnd_shr(c * u - s * v, 22));
		phasor_v[ch] = sat32(rnd_shr(s * u + c * v, 22));
		return sat32(rnd_shr(longint'(phasor_v[ch]) * scale, 22));
	endfunction

	function automatic int comb_lane(int ch, longint x, int whole, longint frac,
			longint gain, longint a, longint scale);
		int base;
		int r0;
		int r1;
		longint b0;
		longint b1;
		longint d;
		longint lp;
		int y;
		base = ch * DLEN;
		r0 = (wpos + DLEN - whole) % DLEN;
		r1 = (wpos + 2 * DLEN - whole - 1) % DLEN;
		b0 = dline[base + r0];
		b1 = dline[base + r1];
		d = b0 + rnd_shr(frac * (b1 - b0), 16);
		lp = smoother[ch];
		lp = sat32(lp + rnd_shr(a * (d - lp), 22));
		smoother[ch] = int'(lp);
		y = sat32(x + rnd_shr(gain * lp, 22));
		dline[base + wpos] = y;
		return sat32(rnd_shr(longint'(y) * scale, 22));
	endfunction

	function automatic void predict_item(bank_item_t it);
		wet_pair_t p;
		int whole;
		longint frac;
		longint a;
		p.l = 0;
		p.r = 0;
		if (it.res < NRES) begin
			if (!bank_mode) begin
				p.l = band_lane(2 * it.res, it.x_l, it.c, it.s, it.scale);
				p.r = band_lane(2 * it.res + 1, it.x_r, it.c, it.s, it.scale);
			end else begin
				a = (smooth_coef > ONE_Q22) ? longint'(ONE_Q22) : longint'(smooth_coef);
				whole = it.whole;
				frac = it.frac;
				if (whole < MIN_DELAY) begin
					whole = MIN_DELAY;
					frac = 0;
				end else if (whole >= DLEN - 3) begin
					whole = DLEN - 3;
					frac = 0;
				end
				p.l = comb_lane(2 * it.res, it.x_l, whole, frac, it.gain, a, it.scale);
				p.r = comb_lane(2 * it.res + 1, it.x_r, whole, frac, it.gain, a, it.scale);
			end
		end
		if (bank_mode && it.sample_last)
			wpos = (wpos + 1) % DLEN;
		wet_q.push_back(p);
	endfunction

	function automatic bank_item_t mk_item(int res, int xl, int xr, int c, int s, int scale,
			int whole, int frac, int gain, bit last);
		bank_item_t it;
		it.res = res;
		it.x_l = xl;
		it.x_r = xr;
		it.c = c;
		it.s = s;
		it.scale = scale;
		it.whole = whole;
		it.frac = frac;
		it.gain = gain;
		it.sample_last = last;
		return it;
	endfunction

	function automatic int rand_sample();
		if ($urandom_range(3) == 0) return int'($urandom);
		return int'($urandom_range(0, 33554431)) - 16777216;
	endfunction

	function automatic int rand_coef();
		logic [31:0] t;
		t = $urandom;
		if ($urandom_range(3) == 0) return int'($signed(t[23:0]));
		return int'($urandom_range(0, 4194303)) - 2097152;
	endfunction

	function automatic bank_item_t rand_item(int res, bit last);
		bank_item_t it;
		int scale;
		int whole;
		scale = ($urandom_range(3) == 0) ? int'($urandom_range(0, 8388607))
			: int'($urandom_range(0, 4194304));
		whole = ($urandom_range(7) == 0) ? int'($urandom_range(0, 2047))
			: int'($urandom_range(2, 40));
		it = mk_item(res, rand_sample(), rand_sample(), rand_coef(), rand_coef(), scale,
			whole, $urandom_range(0, 65535), $urandom_range(0, 4194303), last);
		return it;
	endfunction

	// Waits in_valid low between items only when a gap is taken, so in_valid
	// never gets two assignments in one step.
	task automatic send_item(input bank_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		res_index <= it.res;
		in_left <= it.x_l;
		in_right <= it.x_r;
		coef_cos <= it.c;
		coef_sin <= it.s;
		out_scale <= it.scale;
		delay_whole <= it.whole;
		delay_frac <= it.frac;
		comb_gain <= it.gain;
		sample_end <= it.sample_last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(it);
		n_items++;
	endtask

	task automatic drain_bank();
		in_valid <= 1'b0;
		while (wet_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		drain_bank();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
		if (idx == REG_MODE) begin
			bank_mode = data[0];
			clear_bank();
		end else begin
			smooth_coef = data;
		end
	endtask

	task automatic write_mode(input logic m);
		logic [CFG_W-1:0] d;
		d = $urandom;
		d[0] = m;
		write_reg(REG_MODE, d);
	endtask

	task automatic run_random(input int count);
		int pos;
		pos = 0;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) begin
				send_item(rand_item($urandom_range(0, 15), $urandom_range(1)));
			end else begin
				send_item(rand_item(pos, pos == NRES - 1));
				pos = (pos + 1) % NRES;
			end
		end
	endtask

	task automatic test_band_directed();
		send_item(mk_item(0, 32'sh7fffffff, 32'sh80000000, 8388607, 0, 8388607, 0, 0, 0, 0));
		send_item(mk_item(0, 0, 0, 8388607, -8388608, 8388607, 0, 0, 0, 1));
		send_item(mk_item(0, 0, 0, -8388608, 8388607, 8388607, 0, 0, 0, 0));
		send_item(mk_item(1, 16777216, -16777216, 4194303, 100000, 0, 2047, 65535,
			4194303, 1));
		send_item(mk_item(1, 32'sh80000000, 32'sh7fffffff, -8388608, -8388608, 8388607,
			0, 0, 0, 0));
		send_item(mk_item(11, 16777216, 16777216, 3000000, 2000000, 4194304, 5, 7, 9, 1));
		send_item(mk_item(12, 16777216, 16777216, 3000000, 2000000, 4194304, 5, 7, 9, 1));
		send_item(mk_item(15, -1, -1, -1, -1, 8388607, 2047, 65535, 4194303, 1));
		send_item(mk_item(11, 0, 0, 3000000, 2000000, 4194304, 0, 0, 0, 0));
	endtask

	task automatic test_comb_directed();
		write_mode(1'b1);
		write_reg(REG_SMOOTH, ONE_Q22);
		send_item(mk_item(0, 16777216, -16777216, 0, 0, 4194304, 2, 0, 4194303, 1));
		send_item(mk_item(0, 0, 0, 0, 0, 4194304, 2, 0, 4194303, 1));
		send_item(mk_item(0, 0, 0, 0, 0, 8388607, 2, 65535, 4194303, 1));
		send_item(mk_item(0, 32'sh7fffffff, 32'sh80000000, 0, 0, 8388607, 0, 65535,
			4194303, 1));
		send_item(mk_item(0, 32'sh7fffffff, 32'sh80000000, 0, 0, 8388607, 1, 65535,
			4194303, 1));
		send_item(mk_item(1, 5000, -5000, 0, 0, 4194304, 2045, 65535, 0, 0));
		send_item(mk_item(1, 5000, -5000, 0, 0, 4194304, 2044, 65535, 4194303, 0));
		send_item(mk_item(1, 5000, -5000, 0, 0, 4194304, 2047, 40000, 4194303, 1));
		send_item(mk_item(13, 5000, -5000, 0, 0, 4194304, 3, 100, 4194303, 1));
		write_reg(REG_SMOOTH, 23'h7fffff);
		send_item(mk_item(0, 16777216, 16777216, 0, 0, 4194304, 3, 32768, 2000000, 1));
		send_item(mk_item(0, 0, 0, 0, 0, 4194304, 3, 32768, 2000000, 1));
		write_reg(REG_SMOOTH, 23'd0);
		send_item(mk_item(0, 16777216, 16777216, 0, 0, 4194304, 3, 32768, 2000000, 1));
		send_item(mk_item(0, 0, 0, 0, 0, 4194304, 3, 32768, 2000000, 0));
		write_reg(REG_SMOOTH, SMOOTH_RESET);
	endtask

	task automatic test_random_phase(input int sidle, input int ridle,
			input logic [CFG_W-1:0] smooth_a, input logic [CFG_W-1:0] smooth_b);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		write_mode(1'b0);
		run_random(250);
		write_mode(1'b1);
		write_reg(REG_SMOOTH, smooth_a);
		run_random(180);
		write_reg(REG_SMOOTH, smooth_b);
		run_random(170);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		wet_pair_t want;
		if (out_valid && out_ready) begin
			n_results++;
			if (wet_q.size() == 0) begin
				$display("%0t: result with nothing expected, got %h %h", $time,
					wet_left, wet_right);
				n_errors++;
			end else begin
				want = wet_q.pop_front();
				if (wet_left !== want.l) begin
					$display("%0t: wet_left expected %h got %h", $time, want.l, wet_left);
					n_errors++;
				end
				if (wet_right !== want.r) begin
					$display("%0t: wet_right expected %h got %h", $time, want.r, wet_right);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles at %0t", STALL_LIMIT, $time);
			$display("tb_phasor_and_comb_resonator_bank: errors");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		res_index <= '0;
		in_left <= '0;
		in_right <= '0;
		coef_cos <= '0;
		coef_sin <= '0;
		out_scale <= '0;
		delay_whole <= '0;
		delay_frac <= '0;
		comb_gain <= '0;
		sample_end <= 1'b0;
		out_ready <= 1'b0;
		stall_cycles = 0;
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_cfg = 0;
		send_idle_pct = 9;
		recv_idle_pct = 88;
		bank_mode = 1'b0;
		smooth_coef = SMOOTH_RESET;
		clear_bank();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_band_directed();
		test_comb_directed();
		test_random_phase(9, 88, ONE_Q22, 23'd3000000);
		test_random_phase(88, 9, 23'h7fffff, 23'd0);
		test_random_phase(0, 0, 23'd1, SMOOTH_RESET);

		drain_bank();
		$display("Covered %0d items, %0d results, %0d register writes,", n_items,
			n_results, n_cfg);
		$display("band and comb modes, smoothing extremes and three idling patterns.");
		if (n_errors == 0)
			$display("tb_phasor_and_comb_resonator_bank: clean");
		else
			$display("tb_phasor_and_comb_resonator_bank: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/pcrb_pkg.sv
rtl/core/pcrb_lane.sv
rtl/core/pcrb_merge.sv
rtl/core/phasor_and_comb_resonator_bank.sv
rtl/core/pcrb_checker.sv
sim/tb_phasor_and_comb_resonator_bank.sv
